// ----- rtl/mrb_pkg.sv -----
// Shared types and constants of the message ring buffer.
// Depends on nothing; mrb_ctrl, mrb_dpath and message_ring_buffer import it.
`default_nettype none

package mrb_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W  = 16;

  // Input cmd codes
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // Output kind codes
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_BAD      = 3'd4
  } status_e;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] data_byte;
    logic              last;
    logic [LEN_W-1:0]  req_len;
    logic [LEN_W-1:0]  max_len;
  } in_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] out_byte;
    status_e           status;
    logic              end_of_run;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_DATA
  } state_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_PUT,
    OUT_STAT,
    OUT_BYTE
  } out_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     put_step;
    logic     get_start;
    logic     len_load;
    logic     rd_issue;
    logic     rd_advance;
    out_sel_e out_sel;
    status_e  st_code;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic get_bad;
    logic ring_empty;
    logic rem_zero;
    logic rd_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mrb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module mrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/mrb_ctrl.sv -----
// Controller state machine of the message ring buffer.
// Depends on mrb_pkg; drives mrb_dpath through ctrl_cmd_t.
`default_nettype none

module mrb_ctrl
  import mrb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_cmd_i,
  input  wire logic       in_last_i,
  input  wire dp_stat_t   stat_i,
  output logic            in_ready_o,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;
  logic   byte_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    byte_load  = 1'b0;
    cmd_o      = '{put_step: 1'b0, get_start: 1'b0, len_load: 1'b0, rd_issue: 1'b0,
                   rd_advance: 1'b0, out_sel: OUT_NONE, st_code: ST_OK};
    case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free;
        accept     = in_valid_i && stat_i.out_free;
        if (accept) begin
          if (in_cmd_i == CMD_PUT) begin
            cmd_o.put_step = 1'b1;
            if (in_last_i) begin
              cmd_o.out_sel = OUT_PUT;
            end
          end else if (stat_i.get_bad) begin
            cmd_o.out_sel = OUT_STAT;
            cmd_o.st_code = ST_BAD;
          end else if (stat_i.ring_empty) begin
            cmd_o.out_sel = OUT_STAT;
            cmd_o.st_code = ST_EMPTY;
          end else begin
            cmd_o.get_start = 1'b1;
            state_d         = S_LEN;
          end
        end
      end
      S_LEN: begin
        cmd_o.len_load = 1'b1;
        state_d        = S_DATA;
      end
      S_DATA: begin
        // Move fetched byte to output, refill the read stage behind it
        byte_load      = stat_i.rd_valid && stat_i.out_free;
        cmd_o.rd_issue = !stat_i.rem_zero && (!stat_i.rd_valid || byte_load);
        if (byte_load) begin
          cmd_o.out_sel = OUT_BYTE;
        end else if (stat_i.rem_zero && !stat_i.rd_valid && stat_i.out_free) begin
          cmd_o.out_sel    = OUT_STAT;
          cmd_o.st_code    = ST_OK;
          cmd_o.rd_advance = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mrb_dpath.sv -----
// Datapath of the message ring buffer: slot pointers, put tracking,
// byte and length memories, output register. Depends on mrb_pkg, mrb_ram.
`default_nettype none

module mrb_dpath
  import mrb_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int SLOT_SIZE  = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire in_t        in_data_i,
  input  wire ctrl_cmd_t  cmd_i,
  output dp_stat_t        stat_o,
  output logic            out_valid_o,
  output out_t            out_data_o,
  input  wire logic       out_ready_i
);

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int CW    = $clog2(SLOT_SIZE + 1);
  localparam int DEPTH = SLOT_COUNT * SLOT_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic [SW-1:0] rd_slot_q, rd_slot_d, wr_slot_q, wr_slot_d;
  logic [SW-1:0] rd_next, wr_next;
  logic [CW-1:0] put_cnt_q, put_cnt_d, req_q, req_d, rem_q, rem_d, off_q, off_d;
  logic [CW-1:0] cnt_eff, cnt_new, get_n;
  logic          put_act_q, put_act_d, put_fault_q, put_fault_d;
  logic          fault_new, put_fits, ring_full;
  logic          rv_q, rv_d, out_valid_q, out_valid_d, out_free;
  out_t          out_q, out_d;
  status_e       put_st;

  logic              dat_we, len_we;
  logic [AW-1:0]     dat_waddr, dat_raddr;
  logic [DATA_W-1:0] dat_rdata;
  logic [CW-1:0]     len_rdata;

  assign rd_next   = (rd_slot_q == SW'(SLOT_COUNT - 1)) ? '0 : rd_slot_q + 1'b1;
  assign wr_next   = (wr_slot_q == SW'(SLOT_COUNT - 1)) ? '0 : wr_slot_q + 1'b1;
  assign ring_full = (wr_next == rd_slot_q);
  assign out_free  = !out_valid_q || out_ready_i;

  // A new message restarts the byte count
  assign cnt_eff   = put_act_q ? put_cnt_q : '0;
  assign put_fits  = cnt_eff < CW'(SLOT_SIZE);
  assign cnt_new   = put_fits ? cnt_eff + 1'b1 : cnt_eff;
  assign fault_new = (put_act_q && put_fault_q) || !put_fits;
  assign put_st    = fault_new ? ST_TOO_LONG : (ring_full ? ST_FULL : ST_OK);

  assign dat_we    = cmd_i.put_step && put_fits;
  assign dat_waddr = AW'(wr_slot_q) * AW'(SLOT_SIZE) + AW'(cnt_eff);
  assign dat_raddr = AW'(rd_slot_q) * AW'(SLOT_SIZE) + AW'(off_q);
  assign len_we    = cmd_i.put_step && in_data_i.last && (put_st == ST_OK);

  // Request was bounded by the slot size, so the stored length and the
  // request are the only limits left
  assign get_n = (len_rdata < req_q) ? len_rdata : req_q;

  always_comb begin
    rd_slot_d   = rd_slot_q;
    wr_slot_d   = wr_slot_q;
    put_cnt_d   = put_cnt_q;
    put_act_d   = put_act_q;
    put_fault_d = put_fault_q;
    req_d       = req_q;
    rem_d       = rem_q;
    off_d       = off_q;
    rv_d        = rv_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.put_step) begin
      if (in_data_i.last) begin
        put_act_d   = 1'b0;
        put_cnt_d   = '0;
        put_fault_d = 1'b0;
        if (put_st == ST_OK) begin
          wr_slot_d = wr_next;
        end
      end else begin
        put_act_d   = 1'b1;
        put_cnt_d   = cnt_new;
        put_fault_d = fault_new;
      end
    end

    if (cmd_i.get_start) begin
      req_d = CW'(in_data_i.req_len);
    end
    if (cmd_i.len_load) begin
      rem_d = get_n;
      off_d = '0;
    end
    if (cmd_i.rd_issue) begin
      rem_d = rem_q - 1'b1;
      off_d = off_q + 1'b1;
      rv_d  = 1'b1;
    end else if (cmd_i.out_sel == OUT_BYTE) begin
      rv_d = 1'b0;
    end
    if (cmd_i.rd_advance) begin
      rd_slot_d = rd_next;
    end

    case (cmd_i.out_sel)
      OUT_PUT: begin
        out_d       = '{kind: KIND_STATUS, out_byte: '0, status: put_st, end_of_run: 1'b1};
        out_valid_d = 1'b1;
      end
      OUT_STAT: begin
        out_d       = '{kind: KIND_STATUS, out_byte: '0, status: cmd_i.st_code,
                        end_of_run: 1'b1};
        out_valid_d = 1'b1;
      end
      OUT_BYTE: begin
        out_d       = '{kind: KIND_DATA, out_byte: dat_rdata, status: ST_OK, end_of_run: 1'b0};
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q   <= '0;
      wr_slot_q   <= '0;
      put_cnt_q   <= '0;
      put_act_q   <= 1'b0;
      put_fault_q <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_slot_q   <= rd_slot_d;
      wr_slot_q   <= wr_slot_d;
      put_cnt_q   <= put_cnt_d;
      put_act_q   <= put_act_d;
      put_fault_q <= put_fault_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rem_q <= rem_d;
    off_q <= off_d;
    out_q <= out_d;
  end

  mrb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (in_data_i.data_byte),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (dat_raddr),
    .rdata_o (dat_rdata)
  );

  mrb_ram #(
    .WIDTH (CW),
    .DEPTH (SLOT_COUNT)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (wr_slot_q),
    .wdata_i (cnt_new),
    .re_i    (1'b1),
    .raddr_i (rd_slot_q),
    .rdata_o (len_rdata)
  );

  assign stat_o = '{
    out_free:   out_free,
    get_bad:    (in_data_i.req_len > LEN_W'(SLOT_SIZE)) ||
                (in_data_i.max_len < in_data_i.req_len),
    ring_empty: (rd_slot_q == wr_slot_q),
    rem_zero:   (rem_q == '0),
    rd_valid:   rv_q
  };

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/message_ring_buffer.sv -----
// Top level of the message ring buffer: controller plus datapath.
// Depends on mrb_pkg, mrb_ctrl, mrb_dpath (and mrb_ram below it).
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (in_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_t)
//
// A put word and a rejected get (bad request, empty ring) are taken
// without leaving the idle state. An accepted get holds the input through
// its whole run: the accept, a read of the slot length, a fetch of the
// first byte from the registered byte memory, one byte a cycle while the
// output does not stall, then the final ok status. A zero-length get
// skips the fetch. Reset restores the slot pointers and the put state at
// once; slot contents are not cleared and need no clearing pass.
// An output stall holds the word in the output register and pauses the
// byte stream in place; no input word is taken while the register holds a
// word that does not leave in the same cycle.
`default_nettype none

module message_ring_buffer
  import mrb_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int SLOT_SIZE  = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire in_t   in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_t       out_data_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // Sequence put words, get checks and the byte stream
  mrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_last_i  (in_data_i.last),
    .stat_i     (dp_stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (ctrl_cmd)
  );

  // Hold slot pointers, message storage and the output register
  mrb_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_SIZE  (SLOT_SIZE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_ready_i (out_ready_i)
  );

  // Never fetch past the end of the requested run
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.rd_issue |-> !dp_stat.rem_zero)
    else $error("byte fetch issued with no bytes remaining");

  // Free a slot only when the ring holds a message
  a_advance_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.rd_advance |-> !dp_stat.ring_empty)
    else $error("read slot advanced on an empty ring");

  // An accepted get that passes its checks blocks the input next cycle
  a_get_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.cmd == CMD_GET) &&
     !dp_stat.get_bad && !dp_stat.ring_empty) |=> !in_ready_o)
    else $error("input accepted while a get is streaming");

endmodule

`default_nettype wire
